// ===== rtl/fds_pkg.sv =====
package fds_pkg;

    localparam int FLOAT_W    = 32;
    localparam int EXP_W      = 8;
    localparam int CHAR_W     = 8;
    localparam int STATUS_W   = 2;
    localparam int CFG_W      = 3;
    localparam int FRAC_W     = 24;
    localparam int PROD_W     = FRAC_W + 4;
    localparam int CNT_W      = 5;
    localparam int IDX_W      = 3;
    localparam int INT_DIGITS = 10;
    localparam int BCD_W      = 4 * INT_DIGITS;
    localparam int DIGIT_CNT_W = 4;

    localparam int EXP_BIAS      = 127;
    localparam int MANT_BITS     = 23;
    localparam int EXP_TOO_LARGE = 31;
    localparam int DIGITS_CAP    = 7;

    localparam logic [CFG_W-1:0] FRAC_DIGITS_RESET = CFG_W'(DIGITS_CAP);

    localparam logic [EXP_W-1:0] EXP_LARGE_LIMIT = EXP_W'(EXP_BIAS + EXP_TOO_LARGE);
    localparam logic [EXP_W-1:0] EXP_SMALL_LIMIT = EXP_W'(EXP_BIAS - MANT_BITS);
    localparam logic [EXP_W-1:0] EXP_POINT       = EXP_W'(EXP_BIAS - 1);

    localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_TOO_LARGE = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_TOO_SMALL = 2'd2;

    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_DOT   = 8'h2E;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CHAR_NONE  = 8'h00;

    // command to the alignment / binary-to-bcd unit
    typedef struct packed {
        logic              start;
        logic              shift_digit;
        logic              left;
        logic [CNT_W-1:0]  cnt;
        logic [FRAC_W-1:0] mant;
    } fds_split_cmd_t;

    typedef struct packed {
        logic              busy;
        logic [3:0]        top_digit;
        logic [FRAC_W-1:0] fpart;
    } fds_split_sts_t;

    typedef struct packed {
        logic              start;
        logic [FRAC_W-1:0] fpart;
        logic [IDX_W-1:0]  maxd;
    } fds_frac_cmd_t;

    typedef struct packed {
        logic             busy;
        logic [IDX_W-1:0] nf;
    } fds_frac_sts_t;

    // one double-dabble step: add 3 to digits of 5 or more, then shift in a bit
    function automatic logic [BCD_W-1:0] bcd_step(input logic [BCD_W-1:0] b,
                                                  input logic bit_in);
        logic [BCD_W-1:0] r;
        logic [3:0]       d;
        for (int i = 0; i < INT_DIGITS; i++) begin
            d = b[4*i +: 4];
            if (d >= 4'd5) begin
                d = d + 4'd3;
            end
            r[4*i +: 4] = d;
        end
        return {r[BCD_W-2:0], bit_in};
    endfunction

endpackage

// ===== rtl/fds_float_if.sv =====
interface fds_float_if;
    import fds_pkg::*;

    logic               valid;
    logic               ready;
    logic [FLOAT_W-1:0] float_bits;

    modport source (output valid, output float_bits, input ready);
    modport sink (input valid, input float_bits, output ready);
endinterface

// ===== rtl/fds_char_if.sv =====
interface fds_char_if;
    import fds_pkg::*;

    logic                valid;
    logic                ready;
    logic [CHAR_W-1:0]   text_char;
    logic [STATUS_W-1:0] status;
    logic                last;

    modport source (output valid, output text_char, output status, output last, input ready);
    modport sink (input valid, input text_char, input status, input last, output ready);
endinterface

// ===== rtl/fds_cfg_if.sv =====
interface fds_cfg_if;
    import fds_pkg::*;

    logic             valid;
    logic             ready;
    logic [CFG_W-1:0] frac_digits;

    modport source (output valid, output frac_digits, input ready);
    modport sink (input valid, input frac_digits, output ready);
endinterface

// ===== rtl/float_to_decimal_string.sv =====
// channel    dir  payload                        transfer when
// float_in   in   float_bits[31:0]               valid & ready
// text_out   out  text_char[7:0] status[1:0] last valid & ready
// cfg        in   frac_digits[2:0]               valid & ready (always ready)
//
// an item is taken, then its mantissa is aligned by a shift of n bits (exponent + 1,
// or -exponent - 1) in the serial alignment and bcd shift register; then the
// fraction digits are made while the skipped leading integer zeros are dropped,
// and the sign, integer digits, dot and fraction digits are sent out
// an error sends a single status character; reset clears control state and loads frac_digits 7
// a stall on text_out holds the current character; the next input is taken
// as soon as the last character sits in the output register
module float_to_decimal_string (
    input  logic        clk,
    input  logic        rst_n,
    fds_cfg_if.sink     cfg,
    fds_float_if.sink   float_in,
    fds_char_if.source  text_out
);
    import fds_pkg::*;

    typedef enum logic [7:0] {
        ST_IDLE = 8'b0000_0001,
        ST_ERR  = 8'b0000_0010,
        ST_CONV = 8'b0000_0100,
        ST_PREP = 8'b0000_1000,
        ST_SIGN = 8'b0001_0000,
        ST_INT  = 8'b0010_0000,
        ST_DOT  = 8'b0100_0000,
        ST_FRAC = 8'b1000_0000
    } state_t;

    state_t              state_reg, state_next;
    logic [CFG_W-1:0]    frac_digits_reg;
    logic                neg_reg, neg_next;
    logic [STATUS_W-1:0] err_reg, err_next;
    logic [DIGIT_CNT_W-1:0] int_left_reg, int_left_next;
    logic [IDX_W-1:0]    frac_idx_reg, frac_idx_next;

    logic                out_valid_reg;
    logic [CHAR_W-1:0]   text_char_reg;
    logic [STATUS_W-1:0] status_reg;
    logic                last_reg;

    fds_split_cmd_t split_cmd;
    fds_split_sts_t split_sts;
    fds_frac_cmd_t  frac_cmd;
    fds_frac_sts_t  frac_sts;
    logic [3:0]     frac_digit;

    logic                in_xfer;
    logic                adv;
    logic                emit;
    logic [CHAR_W-1:0]   emit_char;
    logic [STATUS_W-1:0] emit_status;
    logic                emit_last;
    logic [EXP_W-1:0]    exp_field;
    logic                is_zero;
    logic                skip;

    // configuration register, always ready
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            frac_digits_reg <= FRAC_DIGITS_RESET;
        end
        else if (cfg.valid) begin
            frac_digits_reg <= cfg.frac_digits;
        end
    end

    assign float_in.ready = (state_reg == ST_IDLE);
    assign in_xfer        = float_in.valid && float_in.ready;
    assign exp_field      = float_in.float_bits[FLOAT_W-2 -: EXP_W];
    assign is_zero        = (float_in.float_bits[FLOAT_W-2:0] == '0);

    // output slot can take a character this cycle
    assign adv = !out_valid_reg || text_out.ready;

    // leading zero integer digits are dropped, keeping at least one
    assign skip = (int_left_reg > DIGIT_CNT_W'(1)) && (split_sts.top_digit == 4'd0);

    fds_split u_split (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (split_cmd),
        .sts   (split_sts)
    );

    fds_frac u_frac (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (frac_cmd),
        .rd_idx   (frac_idx_reg),
        .sts      (frac_sts),
        .rd_digit (frac_digit)
    );

    always_comb begin
        state_next    = state_reg;
        neg_next      = neg_reg;
        err_next      = err_reg;
        int_left_next = int_left_reg;
        frac_idx_next = frac_idx_reg;

        split_cmd.start       = 1'b0;
        split_cmd.shift_digit = 1'b0;
        split_cmd.left        = 1'b1;
        split_cmd.cnt         = CNT_W'(1);
        split_cmd.mant        = {1'b1, float_in.float_bits[MANT_BITS-1:0]};

        frac_cmd.start = 1'b0;
        frac_cmd.fpart = split_sts.fpart;
        // a count of zero behaves as one
        frac_cmd.maxd  = (frac_digits_reg == '0) ? IDX_W'(1) : frac_digits_reg;

        emit        = 1'b0;
        emit_char   = CHAR_NONE;
        emit_status = STATUS_OK;
        emit_last   = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                if (in_xfer) begin
                    neg_next      = float_in.float_bits[FLOAT_W-1];
                    int_left_next = DIGIT_CNT_W'(INT_DIGITS);
                    if (is_zero) begin
                        // zero of either sign runs as unsigned 0 through the datapath
                        neg_next        = 1'b0;
                        split_cmd.start = 1'b1;
                        split_cmd.mant  = '0;
                        state_next      = ST_CONV;
                    end
                    else if (exp_field >= EXP_LARGE_LIMIT) begin
                        err_next   = STATUS_TOO_LARGE;
                        state_next = ST_ERR;
                    end
                    else if (exp_field < EXP_SMALL_LIMIT) begin
                        err_next   = STATUS_TOO_SMALL;
                        state_next = ST_ERR;
                    end
                    else begin
                        split_cmd.start = 1'b1;
                        if (exp_field > EXP_POINT) begin
                            split_cmd.left = 1'b1;
                            split_cmd.cnt  = CNT_W'(exp_field - EXP_POINT);
                        end
                        else begin
                            split_cmd.left = 1'b0;
                            split_cmd.cnt  = CNT_W'(EXP_POINT - exp_field);
                        end
                        state_next = ST_CONV;
                    end
                end
            end
            ST_ERR: begin
                if (adv) begin
                    emit        = 1'b1;
                    emit_status = err_reg;
                    emit_last   = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            ST_CONV: begin
                if (!split_sts.busy) begin
                    frac_cmd.start = 1'b1;
                    state_next     = ST_PREP;
                end
            end
            ST_PREP: begin
                // fraction digits and leading zero skip run side by side
                if (skip) begin
                    split_cmd.shift_digit = 1'b1;
                    int_left_next         = int_left_reg - 1'b1;
                end
                else if (!frac_sts.busy) begin
                    state_next = neg_reg ? ST_SIGN : ST_INT;
                end
            end
            ST_SIGN: begin
                if (adv) begin
                    emit       = 1'b1;
                    emit_char  = CHAR_MINUS;
                    state_next = ST_INT;
                end
            end
            ST_INT: begin
                if (adv) begin
                    emit                  = 1'b1;
                    emit_char             = CHAR_ZERO + CHAR_W'(split_sts.top_digit);
                    split_cmd.shift_digit = 1'b1;
                    int_left_next         = int_left_reg - 1'b1;
                    if (int_left_reg == DIGIT_CNT_W'(1)) begin
                        state_next = ST_DOT;
                    end
                end
            end
            ST_DOT: begin
                if (adv) begin
                    emit          = 1'b1;
                    emit_char     = CHAR_DOT;
                    frac_idx_next = '0;
                    state_next    = ST_FRAC;
                end
            end
            ST_FRAC: begin
                if (adv) begin
                    emit      = 1'b1;
                    emit_char = CHAR_ZERO + CHAR_W'(frac_digit);
                    emit_last = (IDX_W'(frac_idx_reg + 1'b1) == frac_sts.nf);
                    if (emit_last) begin
                        state_next = ST_IDLE;
                    end
                    else begin
                        frac_idx_next = frac_idx_reg + 1'b1;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            int_left_reg  <= '0;
            frac_idx_reg  <= '0;
        end
        else begin
            state_reg    <= state_next;
            int_left_reg <= int_left_next;
            frac_idx_reg <= frac_idx_next;
            if (emit) begin
                out_valid_reg <= 1'b1;
            end
            else if (text_out.ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk) begin
        neg_reg <= neg_next;
        err_reg <= err_next;
        if (emit) begin
            text_char_reg <= emit_char;
            status_reg    <= emit_status;
            last_reg      <= emit_last;
        end
    end

    assign text_out.valid     = out_valid_reg;
    assign text_out.text_char = text_char_reg;
    assign text_out.status    = status_reg;
    assign text_out.last      = last_reg;

    // a fraction digit read stays inside the kept digits
    a_frac_idx: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FRAC) |-> (frac_idx_reg < frac_sts.nf))
        else $error("fraction index beyond kept digit count");

    // integer emission never runs out of digits
    a_int_left: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_INT) |-> (int_left_reg != '0))
        else $error("integer digit count exhausted");

    // conversion is finished before digits are prepared
    a_prep_split: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_PREP) |-> !split_sts.busy)
        else $error("bcd converter busy during prep");

    // an accepted item goes to conversion or to an error character
    a_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer |=> (state_reg == ST_CONV || state_reg == ST_ERR))
        else $error("unexpected state after input transfer");

    // a new character is loaded only into a free or draining slot
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !text_out.ready) |=> $stable(text_char_reg))
        else $error("stalled character overwritten");

endmodule

// ===== rtl/fds_split.sv =====
module fds_split (
    input  logic                    clk,
    input  logic                    rst_n,
    input  fds_pkg::fds_split_cmd_t cmd,
    output fds_pkg::fds_split_sts_t sts
);
    import fds_pkg::*;

    logic [FRAC_W-1:0] mant_reg;
    logic [BCD_W-1:0]  bcd_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              left_reg;
    logic              busy_reg;

    // control
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            cnt_reg  <= '0;
            left_reg <= 1'b0;
            busy_reg <= 1'b0;
        end
        else if (cmd.start) begin
            cnt_reg  <= cmd.cnt;
            left_reg <= cmd.left;
            busy_reg <= (cmd.cnt != '0);
        end
        else if (busy_reg) begin
            cnt_reg  <= cnt_reg - 1'b1;
            busy_reg <= (cnt_reg != CNT_W'(1));
        end
    end

    // mantissa shifts one bit a cycle; left shifts feed the bcd converter
    always_ff @(posedge clk) begin
        if (cmd.start) begin
            mant_reg <= cmd.mant;
            bcd_reg  <= '0;
        end
        else if (busy_reg) begin
            if (left_reg) begin
                bcd_reg  <= bcd_step(bcd_reg, mant_reg[FRAC_W-1]);
                mant_reg <= {mant_reg[FRAC_W-2:0], 1'b0};
            end
            else begin
                mant_reg <= {1'b0, mant_reg[FRAC_W-1:1]};
            end
        end
        else if (cmd.shift_digit) begin
            bcd_reg <= {bcd_reg[BCD_W-5:0], 4'b0000};
        end
    end

    assign sts.busy      = busy_reg;
    assign sts.top_digit = bcd_reg[BCD_W-1 -: 4];
    assign sts.fpart     = mant_reg;

endmodule

// ===== rtl/fds_frac.sv =====
module fds_frac (
    input  logic                         clk,
    input  logic                         rst_n,
    input  fds_pkg::fds_frac_cmd_t       cmd,
    input  logic [fds_pkg::IDX_W-1:0]    rd_idx,
    output fds_pkg::fds_frac_sts_t       sts,
    output logic [3:0]                   rd_digit
);
    import fds_pkg::*;

    logic [FRAC_W-1:0] frac_reg;
    logic [3:0]        dig_reg [DIGITS_CAP];
    logic [IDX_W-1:0]  idx_reg;
    logic [IDX_W-1:0]  cnt_reg;
    logic [IDX_W-1:0]  nf_reg;
    logic              busy_reg;
    logic [PROD_W-1:0] prod;

    // times ten as two shifts and an add
    assign prod = ({4'b0000, frac_reg} << 3) + ({4'b0000, frac_reg} << 1);

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            idx_reg  <= '0;
            cnt_reg  <= '0;
            nf_reg   <= IDX_W'(1);
            busy_reg <= 1'b0;
        end
        else if (cmd.start) begin
            idx_reg  <= '0;
            cnt_reg  <= cmd.maxd;
            nf_reg   <= IDX_W'(1);
            busy_reg <= (cmd.maxd != '0);
        end
        else if (busy_reg) begin
            if (prod[PROD_W-1 -: 4] != 4'd0) begin
                nf_reg <= idx_reg + 1'b1;
            end
            idx_reg  <= idx_reg + 1'b1;
            cnt_reg  <= cnt_reg - 1'b1;
            busy_reg <= (cnt_reg != IDX_W'(1));
        end
    end

    always_ff @(posedge clk) begin
        if (cmd.start) begin
            frac_reg <= cmd.fpart;
        end
        else if (busy_reg) begin
            frac_reg         <= prod[FRAC_W-1:0];
            dig_reg[idx_reg] <= prod[PROD_W-1 -: 4];
        end
    end

    assign sts.busy = busy_reg;
    assign sts.nf   = nf_reg;
    assign rd_digit = dig_reg[rd_idx];

endmodule
